FILE: src/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       fin_flag;
		logic [3:0] frame_opcode;
		logic       was_masked;
		logic       last_byte;
		logic       empty_frame;
	} out_item_t;

	// 7-bit length codes: 126 announces a 16-bit extended length field, codes above 125 an extended one
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_MAX_SHORT = 7'd125;

	localparam logic [2:0] EXT16_BYTES = 3'd2;
	// eight bytes wrap the 3-bit field counter back to zero
	localparam logic [2:0] EXT64_BYTES = 3'd0;
	localparam int unsigned KEY_BYTES = 4;

endpackage

`default_nettype wire

FILE: src/wsd_stream_if.sv
`default_nettype none

interface wsd_stream_if #(
	parameter type item_t = logic
) ();

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: src/websocket_frame_deframer_core.sv
// a payload or empty-frame result is registered in the output register, or in the skid entry if the output stalls
// throughput: one received byte per cycle, sustained while the result side keeps up
// a two-entry result buffer (output register plus skid) lets input keep flowing while
// the output stalls until the skid fills; rx.ready drops only while the skid entry is occupied
// reset (arst_n low, asynchronous): header parsing restarts, all frame state is
// cleared and the result buffer is emptied
`default_nettype none

module websocket_frame_deframer_core
	import wsd_pkg::*;
#(
	parameter int LENGTH_WIDTH = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	wsd_stream_if.sink   rx,
	wsd_stream_if.source tx
);

	localparam logic [2:0] PH_HEAD = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	localparam int LW = LENGTH_WIDTH;

	logic [2:0]    phase_q, phase_n;
	logic          fin_q, fin_n;
	logic [3:0]    opcode_q, opcode_n;
	logic          mask_q, mask_n;
	logic          ext_long_q, ext_long_n;
	logic [LW-1:0] len_q, len_n;
	logic [2:0]    fbc_q, fbc_n;
	logic [31:0]   key_q, key_n;
	logic [LW-1:0] cnt_q, cnt_n;

	logic          has_res;
	out_item_t     res;

	logic [7:0]    b;
	logic [LW-1:0] len_shift;
	logic [LW-1:0] cnt_inc;
	logic [2:0]    fbc_inc;
	logic [7:0]    key_byte;
	logic          last;

	logic          out_v_q, skid_v_q;
	out_item_t     out_q, skid_q;
	logic          accept, produce, pop;

	assign b         = rx.data.rx_byte;
	assign len_shift = {len_q[LW-9:0], b};
	assign cnt_inc   = cnt_q + {{(LW-1){1'b0}}, 1'b1};
	assign fbc_inc   = fbc_q + 3'd1;
	assign last      = (cnt_inc == len_q);

	always_comb begin
		case (cnt_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		fin_n      = fin_q;
		opcode_n   = opcode_q;
		mask_n     = mask_q;
		ext_long_n = ext_long_q;
		len_n      = len_q;
		fbc_n      = fbc_q;
		key_n      = key_q;
		cnt_n      = cnt_q;
		has_res    = 1'b0;
		res.payload_byte = 8'h00;
		res.fin_flag     = fin_q;
		res.frame_opcode = opcode_q;
		res.was_masked   = mask_q;
		res.last_byte    = 1'b0;
		res.empty_frame  = 1'b0;
		case (phase_q)
			PH_LEN: begin
				mask_n     = b[7];
				ext_long_n = (b[6:0] != LEN_EXT16);
				key_n      = 32'h0;
				fbc_n      = 3'd0;
				res.was_masked = b[7];
				if (b[6:0] > LEN_MAX_SHORT) begin
					len_n   = '0;
					phase_n = PH_EXT;
				end else begin
					len_n = {{(LW-7){1'b0}}, b[6:0]};
					if (b[7]) begin
						phase_n = PH_KEY;
					end else begin
						cnt_n = '0;
						if (b[6:0] == 7'd0) begin
							phase_n = PH_HEAD;
							has_res = 1'b1;
							res.last_byte   = 1'b1;
							res.empty_frame = 1'b1;
						end else begin
							phase_n = PH_DATA;
						end
					end
				end
			end
			PH_EXT: begin
				len_n = len_shift;
				fbc_n = fbc_inc;
				if (fbc_inc == (ext_long_q ? EXT64_BYTES : EXT16_BYTES)) begin
					fbc_n = 3'd0;
					if (mask_q) begin
						phase_n = PH_KEY;
					end else begin
						cnt_n = '0;
						if (len_shift == '0) begin
							phase_n = PH_HEAD;
							has_res = 1'b1;
							res.last_byte   = 1'b1;
							res.empty_frame = 1'b1;
						end else begin
							phase_n = PH_DATA;
						end
					end
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], b};
				fbc_n = fbc_inc;
				if (fbc_inc >= 3'(KEY_BYTES)) begin
					fbc_n = 3'd0;
					cnt_n = '0;
					if (len_q == '0) begin
						phase_n = PH_HEAD;
						has_res = 1'b1;
						res.last_byte   = 1'b1;
						res.empty_frame = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				has_res = 1'b1;
				res.payload_byte = b ^ key_byte;
				res.last_byte    = last;
				if (last) begin
					phase_n = PH_HEAD;
					cnt_n   = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			default: begin
				fin_n    = b[7];
				opcode_n = b[3:0];
				phase_n  = PH_LEN;
			end
		endcase
	end

	assign rx.ready = !skid_v_q;
	assign accept   = rx.valid && rx.ready;
	assign produce  = accept && has_res;
	assign pop      = out_v_q && tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEAD;
			fin_q      <= 1'b0;
			opcode_q   <= 4'h0;
			mask_q     <= 1'b0;
			ext_long_q <= 1'b0;
			len_q      <= '0;
			fbc_q      <= 3'd0;
			key_q      <= 32'h0;
			cnt_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			fin_q      <= fin_n;
			opcode_q   <= opcode_n;
			mask_q     <= mask_n;
			ext_long_q <= ext_long_n;
			len_q      <= len_n;
			fbc_q      <= fbc_n;
			key_q      <= key_n;
			cnt_q      <= cnt_n;
		end
	end

	// result buffer: output register with a one-entry skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end
			end else if (produce && out_v_q && !tx.ready) begin
				skid_v_q <= 1'b1;
			end else if (produce) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (produce && out_v_q && !tx.ready) begin
			skid_q <= res;
		end else if (produce) begin
			out_q <= res;
		end
	end

	assign tx.valid = out_v_q;
	assign tx.data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && out_v_q && !tx.ready) |=> skid_v_q)
		else $error("result lost while output stalled");

	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (len_q != '0))
		else $error("payload phase entered with zero length");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (cnt_q != len_q))
		else $error("payload count reached length without leaving payload phase");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && !tx.ready) |=> (tx.valid && $stable(tx.data)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
